>>> hw/rtl/brace_nested_frame_receiver_unit_defines.svh
// Assertion macros for the brace nested frame receiver.
// Used by the top level only; expects a clock named clk and a reset named rst in scope.
`ifndef BRACE_NESTED_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define BRACE_NESTED_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BNFR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BNFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bnfr_pkg.sv
// Shared types and constants for the brace nested frame receiver.
// No dependencies; imported by the interfaces, the output buffer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bnfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int EVENT_W    = 3;
  localparam int SLOT_OUT_W = 3;
  localparam int POS_OUT_W  = 8;
  localparam int CNT_OUT_W  = 4;
  localparam int DEPTH_W    = 9;
  localparam int TICK_W     = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'd32;
  localparam logic [BYTE_W-1:0] DQUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] SQUOTE     = 8'h27;
  localparam logic [DEPTH_W-1:0] DEPTH_START = 9'h001;

  localparam logic [BYTE_W-1:0] OPEN_CHAR_RST     = 8'd123;
  localparam logic [BYTE_W-1:0] CLOSE_CHAR_RST    = 8'd125;
  localparam logic [TICK_W-1:0] TIMEOUT_LIMIT_RST = 8'd20;

  localparam logic [CFG_IDX_W-1:0] REG_OPEN_CHAR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_CHAR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = 2'd2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE     = 3'd0,
    EV_STORED   = 3'd1,
    EV_COMPLETE = 3'd2,
    EV_OVERFLOW = 3'd3,
    EV_TIMEOUT  = 3'd4
  } event_t;

  typedef struct packed {
    logic [BYTE_W-1:0] open_char;
    logic [BYTE_W-1:0] close_char;
    logic [TICK_W-1:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    event_t                event_res;
    logic [SLOT_OUT_W-1:0] slot;
    logic [POS_OUT_W-1:0]  position;
    logic [BYTE_W-1:0]     stored_byte;
    logic [CNT_OUT_W-1:0]  message_count;
    logic                  receiving;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/bnfr_if.sv
// Valid/ready channel interfaces: input items, results and configuration writes.
// Depends on bnfr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bnfr_in_if;
  import bnfr_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface bnfr_out_if;
  import bnfr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [EVENT_W-1:0]    event_res;
  logic [SLOT_OUT_W-1:0] slot;
  logic [POS_OUT_W-1:0]  position;
  logic [BYTE_W-1:0]     stored_byte;
  logic [CNT_OUT_W-1:0]  message_count;
  logic                  receiving;
  modport source (output valid, output event_res, output slot, output position,
                  output stored_byte, output message_count, output receiving,
                  input ready);
  modport sink   (input valid, input event_res, input slot, input position,
                  input stored_byte, input message_count, input receiving,
                  output ready);
endinterface

interface bnfr_cfg_if;
  import bnfr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/brace_nested_frame_receiver_unit.sv
// Top level of the brace nested frame receiver: framing state, config registers.
// Depends on bnfr_pkg, bnfr_if.sv, bnfr_skid and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "brace_nested_frame_receiver_unit_defines.svh"

// Brace nested frame receiver. Each input transaction (a UART byte or a timer
// tick) produces exactly one result transaction, registered in the output
// buffer on acceptance and held there until result.ready takes it.
// Throughput is one item per clock while item.ready is high: the whole
// framing update is a single pass of combinational logic from the framing
// registers to the result register. A two-entry output buffer (result
// register plus skid register) absorbs stalls of result.ready; ready drops
// only once both entries hold undelivered results. The configuration port is
// always ready; writes take effect on the next item. Index 0 open byte, 1
// close byte, 2 timeout limit; index 3 is ignored. A timeout fires on the
// (timeout_limit + 1)th tick in a frame with no byte between. Slot, position
// and message count on the result are the low bits of the internal values.
module brace_nested_frame_receiver_unit #(
  parameter int BUF_LEN = 256,
  parameter int SLOTS   = 8
) (
  input  logic       clk,
  input  logic       rst,
  bnfr_in_if.sink    item,
  bnfr_out_if.source result,
  bnfr_cfg_if.sink   cfg
);
  import bnfr_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WP_W   = $clog2(BUF_LEN + 1);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // configuration registers
  cfg_t cfg_regs;

  // framing state
  logic               in_frame;
  logic [WP_W-1:0]    write_position;
  logic [DEPTH_W-1:0] nesting_depth;
  logic               inside_quotes;
  logic [SLOT_W-1:0]  current_slot;
  logic [CNT_W-1:0]   completed_count;
  logic [TICK_W-1:0]  idle_ticks;

  logic               in_frame_next;
  logic [WP_W-1:0]    write_position_next;
  logic [DEPTH_W-1:0] nesting_depth_next;
  logic               inside_quotes_next;
  logic [SLOT_W-1:0]  current_slot_next;
  logic [CNT_W-1:0]   completed_count_next;
  logic [TICK_W-1:0]  idle_ticks_next;

  logic               item_fire;
  logic               skid_ready;
  result_t            step_res;
  result_t            buf_res;

  // scratch for the byte path
  logic               quote_toggle;
  logic               keep_byte;
  logic [DEPTH_W-1:0] depth_opened;
  logic [DEPTH_W-1:0] depth_closed;

  assign item.ready = skid_ready;
  assign item_fire  = item.valid && skid_ready;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.open_char     <= OPEN_CHAR_RST;
      cfg_regs.close_char    <= CLOSE_CHAR_RST;
      cfg_regs.timeout_limit <= TIMEOUT_LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_OPEN_CHAR:     cfg_regs.open_char     <= cfg.data;
        REG_CLOSE_CHAR:    cfg_regs.close_char    <= cfg.data;
        REG_TIMEOUT_LIMIT: cfg_regs.timeout_limit <= cfg.data;
        default: ;
      endcase
    end
  end

  // Single-pass framing update.
  always_comb begin
    in_frame_next        = in_frame;
    write_position_next  = write_position;
    nesting_depth_next   = nesting_depth;
    inside_quotes_next   = inside_quotes;
    current_slot_next    = current_slot;
    completed_count_next = completed_count;
    idle_ticks_next      = idle_ticks;

    quote_toggle = (item.rx_byte == DQUOTE) || (item.rx_byte == SQUOTE);
    keep_byte    = (inside_quotes ^ quote_toggle) || (item.rx_byte > CTRL_LIMIT);
    depth_opened = (item.rx_byte == cfg_regs.open_char) ?
                   nesting_depth + DEPTH_W'(1) : nesting_depth;
    depth_closed = depth_opened - DEPTH_W'(1);

    step_res.event_res   = EV_NONE;
    step_res.slot        = SLOT_OUT_W'(current_slot);
    step_res.position    = '0;
    step_res.stored_byte = '0;

    if (item.op == OP_TICK) begin
      if (in_frame) begin
        if (idle_ticks >= cfg_regs.timeout_limit) begin
          // receive timeout: drop the frame
          in_frame_next        = 1'b0;
          write_position_next  = '0;
          nesting_depth_next   = '0;
          idle_ticks_next      = '0;
          completed_count_next = '0;
          step_res.event_res   = EV_TIMEOUT;
        end else begin
          idle_ticks_next = idle_ticks + TICK_W'(1);
        end
      end
    end else begin
      idle_ticks_next = '0;
      if (!in_frame) begin
        // idle: only the open byte matters, stored without quote handling
        if (item.rx_byte == cfg_regs.open_char) begin
          nesting_depth_next   = DEPTH_START;
          in_frame_next        = 1'b1;
          write_position_next  = WP_W'(1);
          step_res.event_res   = EV_STORED;
          step_res.stored_byte = item.rx_byte;
        end
      end else begin
        inside_quotes_next = inside_quotes ^ quote_toggle;
        if (keep_byte) begin
          if (write_position >= WP_W'(BUF_LEN)) begin
            // buffer full: abort before writing past the end
            in_frame_next        = 1'b0;
            write_position_next  = '0;
            nesting_depth_next   = '0;
            idle_ticks_next      = '0;
            completed_count_next = '0;
            step_res.event_res   = EV_OVERFLOW;
          end else begin
            step_res.position    = POS_OUT_W'(write_position);
            step_res.stored_byte = item.rx_byte;
            write_position_next  = write_position + WP_W'(1);
            if ((item.rx_byte == cfg_regs.close_char) && (depth_closed == '0)) begin
              // frame complete; ring advances only while slots remain
              nesting_depth_next = depth_closed;
              if (completed_count < CNT_W'(SLOTS)) begin
                current_slot_next    = (current_slot == SLOT_W'(SLOTS - 1)) ?
                                       '0 : current_slot + SLOT_W'(1);
                completed_count_next = completed_count + CNT_W'(1);
              end
              write_position_next = '0;
              in_frame_next       = 1'b0;
              step_res.event_res  = EV_COMPLETE;
            end else if (item.rx_byte == cfg_regs.close_char) begin
              nesting_depth_next = depth_closed;
              step_res.event_res = EV_STORED;
            end else begin
              nesting_depth_next = depth_opened;
              step_res.event_res = EV_STORED;
            end
          end
        end
      end
    end

    step_res.message_count = CNT_OUT_W'(completed_count_next);
    step_res.receiving     = in_frame_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      write_position  <= '0;
      nesting_depth   <= '0;
      inside_quotes   <= 1'b0;
      current_slot    <= '0;
      completed_count <= '0;
      idle_ticks      <= '0;
    end else if (item_fire) begin
      in_frame        <= in_frame_next;
      write_position  <= write_position_next;
      nesting_depth   <= nesting_depth_next;
      inside_quotes   <= inside_quotes_next;
      current_slot    <= current_slot_next;
      completed_count <= completed_count_next;
      idle_ticks      <= idle_ticks_next;
    end
  end

  bnfr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (skid_ready),
    .in_data   (step_res),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (buf_res)
  );

  assign result.event_res     = buf_res.event_res;
  assign result.slot          = buf_res.slot;
  assign result.position      = buf_res.position;
  assign result.stored_byte   = buf_res.stored_byte;
  assign result.message_count = buf_res.message_count;
  assign result.receiving     = buf_res.receiving;

  // Idle framer holds no partial frame.
  `BNFR_ASSERT_IMPL(a_idle_clean, !in_frame,
    (write_position == '0) && (nesting_depth == '0), "idle with leftover frame state")
  // Message count never exceeds the ring size.
  `BNFR_ASSERT_IMPL(a_count_range, 1'b1, completed_count <= CNT_W'(SLOTS),
    "message count beyond slot count")
  // A timeout tick leaves the framer idle with an empty count.
  `BNFR_ASSERT_NEXT(a_timeout_abort,
    item_fire && (item.op == OP_TICK) && in_frame &&
    (idle_ticks >= cfg_regs.timeout_limit),
    !in_frame && (completed_count == '0), "timeout did not abort the frame")

endmodule

`default_nettype wire

>>> hw/rtl/bnfr_skid.sv
// Two-entry result buffer: output register plus skid register.
// Depends on bnfr_pkg for result_t.
`timescale 1ns / 1ps
`default_nettype none

module bnfr_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bnfr_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bnfr_pkg::result_t out_data
);
  import bnfr_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    in_fire;
  logic    main_free;

  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign main_free = out_ready || !main_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      main_valid <= in_fire || skid_valid;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (in_fire) begin
        main_data <= in_data;
      end
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire
